[hdl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge; skip while reset is asserted
`define CPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising clock edge, reset cycles included
`define CPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/cpc_pkg.sv]
// Shared types, constants and functions of the chunk packetizer
package cpc_pkg;

  localparam int unsigned MaxChunkWords = 127;
  localparam int unsigned FifoDepth     = 4;
  localparam int unsigned FifoPtrW      = $clog2(FifoDepth);
  localparam int unsigned FifoCntW      = $clog2(FifoDepth + 1);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [6:0] ChunkWordsReset = 7'd60;

  // Register indexes on the configuration port
  localparam logic [1:0] RegChunkWords  = 2'd0;
  localparam logic [1:0] RegLittleEnd   = 2'd1;
  localparam logic [1:0] RegIndexBase   = 2'd2;

  // Result kinds
  localparam logic KindData = 1'b0;
  localparam logic KindDesc = 1'b1;

  // One result word as it sits in the output queue
  typedef struct packed {
    logic        kind;
    logic [15:0] word;
    logic [15:0] packet_index;
    logic [7:0]  packet_length;
    logic [15:0] packet_crc;
    logic [15:0] packet_offset;
    logic        final_packet;
    logic        run_last;
  } res_t;

  // Queue status seen by the framer
  typedef struct packed {
    logic nonempty;
    logic no_room;
  } fifo_stat_t;

  // Advance a CRC-16/Modbus accumulator by one byte (LSB first)
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Pack two bytes into a word in the selected byte order
  function automatic logic [15:0] pack_word(input logic [7:0] first, input logic [7:0] second,
                                            input logic le);
    return le ? {second, first} : {first, second};
  endfunction

endpackage

[hdl/cpc_res_fifo.sv]
// Small result queue: takes up to two words per cycle, hands out one
module cpc_res_fifo import cpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  res_t       push_a_i,
  input  res_t       push_b_i,
  input  logic       pop_i,
  output res_t       head_o,
  output fifo_stat_t stat_o
);

  res_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic [FifoPtrW-1:0] wr_ptr_b;

  assign wr_ptr_b = wr_ptr_q + FifoPtrW'(1);

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop_i);
    count_d  = count_q + FifoCntW'(push_cnt_i) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write one or two entries at the tail
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_a_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_b] <= push_b_i;
    end
  end

  assign head_o          = mem_q[rd_ptr_q];
  assign stat_o.nonempty = (count_q != '0);
  assign stat_o.no_room  = (count_q > FifoCntW'(FifoDepth - 2));

endmodule

[hdl/chunk_packetizer_crc16.sv]
// Top level of the chunk packetizer with CRC-16/Modbus descriptors
//
// Input channel: one payload byte per word (data_byte_i, last_byte_i), handshake
// in_valid_i / in_stall_o. Output channel: one result per word, either a packed
// 16-bit data word (kind 0) or a chunk descriptor (kind 1) that trails the chunk's
// last data word; handshake out_valid_o / out_stall_i.
// Each input byte is framed in the cycle it is accepted and its results are
// registered in a four-entry result queue before they are offered. One byte can
// be taken per cycle while in_stall_o is low. A byte that completes a word yields
// one result, a byte that closes a chunk yields two, a held odd byte yields none.
// The output side delivers one result per cycle while out_stall_i is low, so
// back-to-back one-byte payloads (two results each) are paced by it. The queue
// depth sets how long the input keeps up while the receiver stalls: in_stall_o
// rises once the queue cannot take two more results and falls as they are taken.
// Reset empties the queue, clears the framing state (CRC to 0xFFFF, counts to
// zero) and loads the register defaults: 60 words per chunk, big-endian packing,
// index base 0. Registers are written over the APB port at byte address 4*i.
module chunk_packetizer_crc16 import cpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [15:0] word_o,
  output logic [15:0] packet_index_o,
  output logic [7:0]  packet_length_o,
  output logic [15:0] packet_crc_o,
  output logic [15:0] packet_offset_o,
  output logic        final_packet_o,
  output logic        run_last_o
);

  // Configuration registers
  logic [6:0]  chunk_words_q;
  logic        little_endian_q;
  logic [15:0] index_base_q;

  // Framing state
  logic [15:0] crc_q, crc_d;
  logic [7:0]  bytes_q, bytes_d;
  logic [7:0]  held_byte_q;
  logic        held_valid_q, held_valid_d;
  logic [15:0] chunk_num_q, chunk_num_d;
  logic [15:0] chunk_start_q, chunk_start_d;

  logic        in_take;
  logic        cfg_wr;
  logic [6:0]  cw;
  logic [7:0]  limit;
  logic [15:0] crc_next;
  logic [7:0]  cnt_next;
  logic        word_done;
  logic        close;
  logic [15:0] w;
  logic [1:0]  push_cnt;
  res_t        res_word, res_desc, head;
  fifo_stat_t  fstat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign in_take = in_valid_i && !in_stall_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_words_q   <= ChunkWordsReset;
      little_endian_q <= 1'b0;
      index_base_q    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegChunkWords: chunk_words_q   <= pwdata[6:0];
        RegLittleEnd:  little_endian_q <= pwdata[0];
        RegIndexBase:  index_base_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (paddr[3:2])
      RegChunkWords: prdata = {25'd0, chunk_words_q};
      RegLittleEnd:  prdata = {31'd0, little_endian_q};
      RegIndexBase:  prdata = {16'd0, index_base_q};
      default:       prdata = '0;
    endcase
  end

  // Frame the incoming byte
  always_comb begin
    cw        = (chunk_words_q == 7'd0) ? 7'd1
              : (chunk_words_q > 7'(MaxChunkWords)) ? 7'(MaxChunkWords) : chunk_words_q;
    limit     = {cw, 1'b0};
    crc_next  = crc_byte(crc_q, data_byte_i);
    cnt_next  = bytes_q + 8'd1;
    word_done = held_valid_q || last_byte_i;
    w         = held_valid_q ? pack_word(held_byte_q, data_byte_i, little_endian_q)
                             : pack_word(data_byte_i, 8'h00, little_endian_q);
    close     = word_done && (last_byte_i || (cnt_next >= limit));

    held_valid_d  = !held_valid_q && !last_byte_i;
    crc_d         = close ? CrcInit : crc_next;
    bytes_d       = close ? 8'd0 : cnt_next;
    chunk_num_d   = chunk_num_q;
    chunk_start_d = chunk_start_q;
    if (close) begin
      chunk_num_d   = last_byte_i ? 16'd0 : chunk_num_q + 16'd1;
      chunk_start_d = last_byte_i ? 16'd0 : chunk_start_q + {8'd0, cnt_next};
    end

    res_word               = '0;
    res_word.kind          = KindData;
    res_word.word          = w;
    res_word.run_last      = !close;

    res_desc               = '0;
    res_desc.kind          = KindDesc;
    res_desc.packet_index  = index_base_q + chunk_num_q;
    res_desc.packet_length = cnt_next;
    res_desc.packet_crc    = crc_next;
    res_desc.packet_offset = chunk_start_q;
    res_desc.final_packet  = last_byte_i;
    res_desc.run_last      = 1'b1;

    if (!in_take) begin
      push_cnt = 2'd0;
    end else if (close) begin
      push_cnt = 2'd2;
    end else if (word_done) begin
      push_cnt = 2'd1;
    end else begin
      push_cnt = 2'd0;
    end
  end

  // Update framing state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q         <= CrcInit;
      bytes_q       <= '0;
      held_valid_q  <= 1'b0;
      chunk_num_q   <= '0;
      chunk_start_q <= '0;
    end else if (in_take) begin
      crc_q         <= crc_d;
      bytes_q       <= bytes_d;
      held_valid_q  <= held_valid_d;
      chunk_num_q   <= chunk_num_d;
      chunk_start_q <= chunk_start_d;
    end
  end

  // Hold the first byte of a pair
  always_ff @(posedge clk_i) begin
    if (in_take && held_valid_d) begin
      held_byte_q <= data_byte_i;
    end
  end

  cpc_res_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_cnt_i (push_cnt),
    .push_a_i   (res_word),
    .push_b_i   (res_desc),
    .pop_i      (out_valid_o && !out_stall_i),
    .head_o     (head),
    .stat_o     (fstat)
  );

  assign in_stall_o      = fstat.no_room;
  assign out_valid_o     = fstat.nonempty;
  assign kind_o          = head.kind;
  assign word_o          = head.word;
  assign packet_index_o  = head.packet_index;
  assign packet_length_o = head.packet_length;
  assign packet_crc_o    = head.packet_crc;
  assign packet_offset_o = head.packet_offset;
  assign final_packet_o  = head.final_packet;
  assign run_last_o      = head.run_last;

endmodule

[hdl/cpc_checker.sv]
// Port-level checks on the chunk packetizer, bound to the top level
`include "assert_macros.svh"

module cpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [15:0] word_o,
  input logic        final_packet_o,
  input logic        run_last_o
);

  logic        closing_word;
  logic        final_seen;
  logic        in_take;
  logic        out_wait;
  logic [16:0] head_key;

  assign closing_word = out_valid_o && !out_stall_i && !kind_o && !run_last_o;
  assign final_seen   = out_valid_o && final_packet_o;
  assign in_take      = in_valid_i && !in_stall_o;
  assign out_wait     = out_valid_o && out_stall_i;
  assign head_key     = {kind_o, word_o};

  // No result is offered while reset is held
  `CPC_ASSERT_ALWAYS(a_idle_in_reset, (!rst_ni ##1 !rst_ni |-> !out_valid_o), "valid in reset")

  // A data word that is not the last result of its byte is followed by the descriptor
  `CPC_ASSERT(a_desc_follows, (closing_word |=> out_valid_o && kind_o), "trailer missing")

  // The final-packet flag only rides on a descriptor that ends its byte's results
  `CPC_ASSERT(a_final_is_desc, (final_seen |-> kind_o && run_last_o), "stray final flag")

  // Input stall only rises after a byte was taken
  `CPC_ASSERT(a_stall_cause, ($rose(in_stall_o) |-> $past(in_take)), "stall without input")

  // A stalled result holds its kind and word
  `CPC_ASSERT(a_out_hold, (out_wait |=> out_valid_o && $stable(head_key)), "result changed")

endmodule

bind chunk_packetizer_crc16 cpc_checker u_cpc_checker (.*);
